// ===== rtl/core/thle_pkg.sv =====
// Shared types, constants and helper functions of the Tektronix hex line encoder.
package thle_pkg;

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Record type codes
    localparam logic [2:0] REC_HEADER = 3'd0;
    localparam logic [2:0] REC_DATA   = 3'd1;
    localparam logic [2:0] REC_COUNT  = 3'd2;
    localparam logic [2:0] REC_START  = 3'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_DATA_ADDR  = 2'd1;
    localparam logic [1:0] ERR_START_ADDR = 2'd2;
    localparam logic [1:0] ERR_TYPE       = 2'd3;

    // Highest end address of a data record, plus one
    localparam logic [32:0] ADDR_LIMIT = 33'd65536;

    // ASCII characters
    localparam logic [6:0] CHAR_SLASH   = 7'h2F;
    localparam logic [6:0] CHAR_NEWLINE = 7'h0A;
    localparam logic [6:0] CHAR_NONE    = 7'h00;

    // Character positions within one line
    localparam logic [3:0] STEP_SLASH   = 4'd0;
    localparam logic [3:0] STEP_ADDR_3  = 4'd1;
    localparam logic [3:0] STEP_ADDR_2  = 4'd2;
    localparam logic [3:0] STEP_ADDR_1  = 4'd3;
    localparam logic [3:0] STEP_ADDR_0  = 4'd4;
    localparam logic [3:0] STEP_LEN_HI  = 4'd5;
    localparam logic [3:0] STEP_LEN_LO  = 4'd6;
    localparam logic [3:0] STEP_HSUM_HI = 4'd7;
    localparam logic [3:0] STEP_HSUM_LO = 4'd8;
    localparam logic [3:0] STEP_DATA_HI = 4'd9;
    localparam logic [3:0] STEP_DATA_LO = 4'd10;
    localparam logic [3:0] STEP_CSUM_HI = 4'd11;
    localparam logic [3:0] STEP_CSUM_LO = 4'd12;
    localparam logic [3:0] STEP_NEWLINE = 4'd13;

    // One classified item, as handed from front to back
    typedef struct packed {
        logic        is_error;
        logic [1:0]  error_code;
        logic        has_header;
        logic [15:0] addr;
        logic [7:0]  len;
        logic [7:0]  hsum;
        logic        has_data;
        logic [7:0]  data;
        logic        has_close;
        logic        has_newline;
        logic [7:0]  csum;
    } thle_job_t;

    // Uppercase hex digit of one nibble
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] wide;
        begin
            wide = {3'b000, nib};
            if (nib < 4'd10)
            begin
                hex_char = 7'h30 + wide;
            end
            else
            begin
                hex_char = 7'h37 + wide;
            end
        end
    endfunction

    // Sum of the two nibbles of a byte
    function automatic logic [7:0] nib_sum(input logic [7:0] b);
        begin
            nib_sum = {4'b0000, b[7:4]} + {4'b0000, b[3:0]};
        end
    endfunction

endpackage

// ===== rtl/core/thle_front.sv =====
// Front part: accepts records, tracks the open record and classifies each item into a job.
module thle_front
    import thle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  record_type,
    input  logic [31:0] address,
    input  logic [7:0]  record_length,
    input  logic [7:0]  data_byte,
    input  logic        queue_full,
    output logic        push,
    output thle_job_t   push_job
);

    logic       suppress_reg;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic [7:0] nibble_sum_reg;
    logic [7:0] nibble_sum_next;

    logic        accept;
    logic        produce;
    logic [32:0] end_addr;
    logic [7:0]  byte_sum;
    logic [7:0]  run_sum;
    logic [7:0]  head_sum;
    thle_job_t   job;

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && produce;
    assign push_job = job;

    assign end_addr = {1'b0, address} + {25'd0, record_length};
    assign byte_sum = nib_sum(data_byte);
    assign run_sum  = nibble_sum_reg + byte_sum;
    assign head_sum = nib_sum(address[15:8]) + nib_sum(address[7:0]) + nib_sum(record_length);

    // Classify the item and work out the record state after it
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        nibble_sum_next = nibble_sum_reg;
        produce         = 1'b0;
        job             = '0;
        job.addr        = address[15:0];
        job.data        = data_byte;
        job.error_code  = ERR_NONE;
        if ((bytes_left_reg != 8'd0) && (record_type == REC_DATA))
        begin
            // Continue the open record
            produce         = 1'b1;
            job.has_data    = 1'b1;
            bytes_left_next = bytes_left_reg - 8'd1;
            nibble_sum_next = run_sum;
            if (bytes_left_reg == 8'd1)
            begin
                job.has_close   = 1'b1;
                job.has_newline = 1'b1;
                job.csum        = run_sum;
                nibble_sum_next = 8'd0;
            end
        end
        else
        begin
            // Drop any open record and start fresh
            bytes_left_next = 8'd0;
            nibble_sum_next = 8'd0;
            case (record_type)
                REC_HEADER, REC_COUNT:
                begin
                    produce = 1'b0;
                end
                REC_DATA:
                begin
                    if (record_length == 8'd0)
                    begin
                        produce = 1'b0;
                    end
                    else if (end_addr > ADDR_LIMIT)
                    begin
                        produce        = 1'b1;
                        job.is_error   = 1'b1;
                        job.error_code = ERR_DATA_ADDR;
                    end
                    else
                    begin
                        produce         = 1'b1;
                        job.has_header  = 1'b1;
                        job.len         = record_length;
                        job.hsum        = head_sum;
                        job.has_data    = 1'b1;
                        bytes_left_next = record_length - 8'd1;
                        nibble_sum_next = byte_sum;
                        if (record_length == 8'd1)
                        begin
                            job.has_close   = 1'b1;
                            job.has_newline = 1'b1;
                            job.csum        = byte_sum;
                            nibble_sum_next = 8'd0;
                        end
                    end
                end
                REC_START:
                begin
                    if (suppress_reg)
                    begin
                        produce = 1'b0;
                    end
                    else if (address[31:16] != 16'd0)
                    begin
                        produce        = 1'b1;
                        job.is_error   = 1'b1;
                        job.error_code = ERR_START_ADDR;
                    end
                    else
                    begin
                        produce         = 1'b1;
                        job.has_header  = 1'b1;
                        job.len         = 8'd0;
                        job.hsum        = nib_sum(address[15:8]) + nib_sum(address[7:0]);
                        job.has_newline = 1'b1;
                    end
                end
                default:
                begin
                    produce        = 1'b1;
                    job.is_error   = 1'b1;
                    job.error_code = ERR_TYPE;
                end
            endcase
        end
    end

    // Hold configuration and record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            suppress_reg   <= 1'b0;
            bytes_left_reg <= 8'd0;
            nibble_sum_reg <= 8'd0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                suppress_reg <= cfg_write_data;
            end
            if (accept)
            begin
                bytes_left_reg <= bytes_left_next;
                nibble_sum_reg <= nibble_sum_next;
            end
        end
    end

endmodule

// ===== rtl/core/thle_queue.sv =====
// Short job queue between the front and back parts.
module thle_queue
    import thle_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  thle_job_t push_job,
    input  logic      pop,
    output logic      full,
    output logic      head_valid,
    output thle_job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    thle_job_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/thle_back.sv =====
// Back part: walks each job one character per cycle into the output register while out_stall is low.
module thle_back
    import thle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  thle_job_t  head_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] text_char,
    output logic       last_of_run,
    output logic [1:0] error_code
);

    logic       started_reg;
    logic [3:0] step_reg;
    logic       out_valid_reg;
    logic [6:0] text_char_reg;
    logic       last_reg;
    logic [1:0] error_code_reg;

    logic       load;
    logic [3:0] cur;
    logic [3:0] step_next;
    logic       job_done;
    logic [3:0] nib;
    logic [6:0] char_next;

    assign out_valid   = out_valid_reg;
    assign text_char   = text_char_reg;
    assign last_of_run = last_reg;
    assign error_code  = error_code_reg;

    assign load = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = load && job_done;

    // Pick the current position within the head job
    always_comb
    begin
        if (started_reg)
        begin
            cur = step_reg;
        end
        else if (head_job.has_header)
        begin
            cur = STEP_SLASH;
        end
        else
        begin
            cur = STEP_DATA_HI;
        end
    end

    // Find the next position, skipping parts the job lacks
    always_comb
    begin
        step_next = cur + 4'd1;
        job_done  = 1'b0;
        if (head_job.is_error)
        begin
            job_done = 1'b1;
        end
        else
        begin
            case (cur)
                STEP_HSUM_LO:
                begin
                    if (head_job.has_data)
                    begin
                        step_next = STEP_DATA_HI;
                    end
                    else if (head_job.has_newline)
                    begin
                        step_next = STEP_NEWLINE;
                    end
                    else
                    begin
                        job_done = 1'b1;
                    end
                end
                STEP_DATA_LO:
                begin
                    if (head_job.has_close)
                    begin
                        step_next = STEP_CSUM_HI;
                    end
                    else
                    begin
                        job_done = 1'b1;
                    end
                end
                STEP_CSUM_LO:
                begin
                    step_next = STEP_NEWLINE;
                end
                STEP_NEWLINE:
                begin
                    job_done = 1'b1;
                end
                default:
                begin
                    step_next = cur + 4'd1;
                end
            endcase
        end
    end

    // Select the nibble shown at the current position
    always_comb
    begin
        case (cur)
            STEP_ADDR_3:  nib = head_job.addr[15:12];
            STEP_ADDR_2:  nib = head_job.addr[11:8];
            STEP_ADDR_1:  nib = head_job.addr[7:4];
            STEP_ADDR_0:  nib = head_job.addr[3:0];
            STEP_LEN_HI:  nib = head_job.len[7:4];
            STEP_LEN_LO:  nib = head_job.len[3:0];
            STEP_HSUM_HI: nib = head_job.hsum[7:4];
            STEP_HSUM_LO: nib = head_job.hsum[3:0];
            STEP_DATA_HI: nib = head_job.data[7:4];
            STEP_DATA_LO: nib = head_job.data[3:0];
            STEP_CSUM_HI: nib = head_job.csum[7:4];
            STEP_CSUM_LO: nib = head_job.csum[3:0];
            default:      nib = 4'd0;
        endcase
    end

    // Form the character
    always_comb
    begin
        if (head_job.is_error)
        begin
            char_next = CHAR_NONE;
        end
        else if (cur == STEP_SLASH)
        begin
            char_next = CHAR_SLASH;
        end
        else if (cur == STEP_NEWLINE)
        begin
            char_next = CHAR_NEWLINE;
        end
        else
        begin
            char_next = hex_char(nib);
        end
    end

    // Advance the position within the job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            step_reg      <= STEP_SLASH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                started_reg <= !job_done;
                step_reg    <= step_next;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the character until it is transferred
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            text_char_reg  <= char_next;
            last_reg       <= job_done;
            error_code_reg <= head_job.is_error ? head_job.error_code : ERR_NONE;
        end
    end

endmodule

// ===== rtl/core/tektronix_hex_line_encoder.sv =====
// Idle back part: an item is stored in the queue, then its first character in the output register.
// Throughput: one character per cycle when unstalled, set by the single character output register.
// A data byte is two characters; the first byte adds the header, the last the checksum and newline.
// An item is taken every cycle while the job queue has room.
// Reset (rst_n, asynchronous): no record open, checksum zero, queue empty,
// start-address lines enabled.
module tektronix_hex_line_encoder
    import thle_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  record_type,
    input  logic [31:0] address,
    input  logic [7:0]  record_length,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  text_char,
    output logic        last_of_run,
    output logic [1:0]  error_code
);

    logic      queue_full;
    logic      push;
    thle_job_t push_job;
    logic      pop;
    logic      head_valid;
    thle_job_t head_job;

    // Accept and classify items
    thle_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .record_type    (record_type),
        .address        (address),
        .record_length  (record_length),
        .data_byte      (data_byte),
        .queue_full     (queue_full),
        .push           (push),
        .push_job       (push_job)
    );

    // Buffer jobs between the two sides
    thle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Emit characters
    thle_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .text_char   (text_char),
        .last_of_run (last_of_run),
        .error_code  (error_code)
    );

endmodule
